@@ rtl/bsad_pkg.sv @@
// ----------------------------------------------------------------------------
// bsad_pkg: shared types and constants
// Widths, mode codes and register indexes for the block SAD engine.
// ----------------------------------------------------------------------------
`default_nettype none

package bsad_pkg;

  localparam int PIX_W          = 8;
  localparam int PIXELS_PER_ROW = 8;
  localparam int ROW_W          = PIX_W * PIXELS_PER_ROW;
  localparam int BLOCK_ROWS     = 8;
  localparam int ROW_IDX_W      = 3;
  localparam int ROWS_W         = 4;
  localparam int SUM_W          = 14;
  // Largest row sum is 8 * 255 = 2040.
  localparam int ROW_SAD_W      = 11;
  localparam int CFG_DATA_W     = 14;
  localparam int CFG_IDX_W      = 1;

  typedef enum logic [1:0] {
    MODE_PLAIN   = 2'd0,
    MODE_THRESH  = 2'd1,
    MODE_HALFPEL = 2'd2
  } sad_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IDX_MODE   = 1'b0,
    CFG_IDX_THRESH = 1'b1
  } cfg_idx_t;

  // Row result handed from the row stage to the accumulator.
  typedef struct packed {
    logic                 valid;
    logic [ROW_SAD_W-1:0] sad;
  } row_res_t;

endpackage

`default_nettype wire

@@ rtl/bsad_if.sv @@
// ----------------------------------------------------------------------------
// bsad_in_if / bsad_out_if: valid-ready channels
// Row input channel and block result channel of the SAD engine.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsad_in_if;
  logic                       valid;
  logic                       ready;
  logic [bsad_pkg::ROW_W-1:0] source_row;
  logic [bsad_pkg::ROW_W-1:0] reference_row_a;
  logic [bsad_pkg::ROW_W-1:0] reference_row_b;

  modport source (output valid, output source_row, output reference_row_a,
                  output reference_row_b, input ready);
  modport sink   (input valid, input source_row, input reference_row_a,
                  input reference_row_b, output ready);
endinterface

interface bsad_out_if;
  logic                        valid;
  logic                        ready;
  logic [bsad_pkg::SUM_W-1:0]  block_sad;
  logic [bsad_pkg::ROWS_W-1:0] rows_used;
  logic                        stopped_early;

  modport source (output valid, output block_sad, output rows_used,
                  output stopped_early, input ready);
  modport sink   (input valid, input block_sad, input rows_used,
                  input stopped_early, output ready);
endinterface

`default_nettype wire

@@ rtl/bsad_row.sv @@
// ----------------------------------------------------------------------------
// bsad_row: row capture and row SAD
// Registers one input row, then sums its eight absolute differences into
// a registered row result.
// ----------------------------------------------------------------------------
`default_nettype none

module bsad_row (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [bsad_pkg::ROW_W-1:0] source_row,
  input  wire logic [bsad_pkg::ROW_W-1:0] reference_row_a,
  input  wire logic [bsad_pkg::ROW_W-1:0] reference_row_b,
  input  wire logic                       halfpel,
  output bsad_pkg::row_res_t              row_res,
  input  wire logic                       row_ready
);

  logic                       a_valid_r;
  logic [bsad_pkg::ROW_W-1:0] src_r, ra_r, rb_r;
  logic                       halfpel_r;
  logic                       b_valid_r;
  logic [bsad_pkg::ROW_SAD_W-1:0] sad_r;
  logic [bsad_pkg::ROW_SAD_W-1:0] sad_nxt;
  logic                       b_ready;
  logic                       a_ready;

  assign b_ready  = !b_valid_r || row_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign in_ready = a_ready;

  always_comb begin
    logic [bsad_pkg::PIX_W-1:0] s, r;
    logic [bsad_pkg::PIX_W:0]   avg;
    logic [bsad_pkg::PIX_W-1:0] d;
    sad_nxt = '0;
    for (int k = 0; k < bsad_pkg::PIXELS_PER_ROW; k++) begin
      s   = src_r[k*bsad_pkg::PIX_W +: bsad_pkg::PIX_W];
      avg = {1'b0, ra_r[k*bsad_pkg::PIX_W +: bsad_pkg::PIX_W]}
          + {1'b0, rb_r[k*bsad_pkg::PIX_W +: bsad_pkg::PIX_W]};
      r   = halfpel_r ? avg[bsad_pkg::PIX_W:1]
                      : ra_r[k*bsad_pkg::PIX_W +: bsad_pkg::PIX_W];
      d   = (s > r) ? (s - r) : (r - s);
      sad_nxt = sad_nxt + {{(bsad_pkg::ROW_SAD_W-bsad_pkg::PIX_W){1'b0}}, d};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_r <= in_valid;
      end
      if (b_ready) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  // Payload: hold while stalled.
  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      src_r     <= source_row;
      ra_r      <= reference_row_a;
      rb_r      <= reference_row_b;
      halfpel_r <= halfpel;
    end
    if (b_ready && a_valid_r) begin
      sad_r <= sad_nxt;
    end
  end

  assign row_res.valid = b_valid_r;
  assign row_res.sad   = sad_r;

endmodule

`default_nettype wire

@@ rtl/bsad_acc.sv @@
// ----------------------------------------------------------------------------
// bsad_acc: block accumulator and result register
// Adds row sums into the block total, applies the threshold stop, skips
// the rest of a stopped block and registers one result per block.
// ----------------------------------------------------------------------------
`default_nettype none

module bsad_acc (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire bsad_pkg::row_res_t         row_res,
  output logic                            row_ready,
  input  wire logic                       use_thres,
  input  wire logic [bsad_pkg::SUM_W-1:0] threshold,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [bsad_pkg::SUM_W-1:0]      block_sad,
  output logic [bsad_pkg::ROWS_W-1:0]     rows_used,
  output logic                            stopped_early
);

  logic [bsad_pkg::SUM_W-1:0]     sum_r, sum_nxt, acc_sum;
  logic [bsad_pkg::ROW_IDX_W-1:0] row_idx_r, row_idx_nxt;
  logic                           skip_r, skip_nxt;
  logic                           out_valid_r;
  logic [bsad_pkg::SUM_W-1:0]     out_sad_r;
  logic [bsad_pkg::ROWS_W-1:0]    out_rows_r;
  logic                           out_early_r;

  logic [bsad_pkg::ROWS_W-1:0] rows;
  logic                        last_row, over, produce, fire;

  assign rows     = {1'b0, row_idx_r} + bsad_pkg::ROWS_W'(1);
  assign last_row = (rows >= bsad_pkg::ROWS_W'(bsad_pkg::BLOCK_ROWS));
  assign acc_sum  = sum_r + {{(bsad_pkg::SUM_W-bsad_pkg::ROW_SAD_W){1'b0}}, row_res.sad};
  assign over     = use_thres && (acc_sum > threshold);
  assign produce  = !skip_r && (over || last_row);
  // A row that makes no result never waits on the output register.
  assign fire      = row_res.valid && (!produce || !out_valid_r || out_ready);
  assign row_ready = !produce || !out_valid_r || out_ready;

  always_comb begin
    sum_nxt     = sum_r;
    row_idx_nxt = row_idx_r;
    skip_nxt    = skip_r;
    if (fire) begin
      if (last_row) begin
        sum_nxt     = '0;
        row_idx_nxt = '0;
        skip_nxt    = 1'b0;
      end else begin
        row_idx_nxt = rows[bsad_pkg::ROW_IDX_W-1:0];
        if (!skip_r) begin
          sum_nxt  = acc_sum;
          skip_nxt = over;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      row_idx_r   <= '0;
      skip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r     <= sum_nxt;
      row_idx_r <= row_idx_nxt;
      skip_r    <= skip_nxt;
      if (fire && produce) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && produce) begin
      out_sad_r   <= acc_sum;
      out_rows_r  <= rows;
      out_early_r <= !last_row;
    end
  end

  assign out_valid     = out_valid_r;
  assign block_sad     = out_sad_r;
  assign rows_used     = out_rows_r;
  assign stopped_early = out_early_r;

endmodule

`default_nettype wire

@@ rtl/block_sad_with_early_exit_top.sv @@
// ----------------------------------------------------------------------------
// block_sad_with_early_exit_top: 8x8 block SAD with threshold early exit
// Top level: configuration registers, row stage and accumulator.
// ----------------------------------------------------------------------------
// Each input transaction carries one row of eight 8-bit source pixels and two
// reference rows; eight rows make a block, and one result transaction leaves
// per block with the sum, the rows used and an early-stop flag. The block
// takes one row per clock cycle when the result side keeps up; a row that
// ends a block passes the input register and then the row SAD register,
// after which the accumulator writes the result register; the accumulator's
// add and compare of the running sum against the threshold is the one loop.
// In threshold and half-pel modes a block ends after the first row whose
// running sum exceeds the threshold register; the remaining rows of that
// block are accepted and dropped. Mode 3 behaves as plain mode. Write
// cfg_index 0 for the mode, 1 for the threshold, only while no rows are in
// flight; the half-pel choice is taken with each row as it is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module block_sad_with_early_exit_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  bsad_in_if.sink                              in_ch,
  bsad_out_if.source                           out_ch,
  input  wire logic                            cfg_wr_en,
  input  wire logic [bsad_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bsad_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [1:0]                 mode_r;
  logic [bsad_pkg::SUM_W-1:0] thresh_r;
  logic                       use_thres, halfpel;
  bsad_pkg::row_res_t         row_res;
  logic                       row_ready;

  // Configuration registers; reset to plain mode, threshold at maximum.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= bsad_pkg::MODE_PLAIN;
      thresh_r <= '1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bsad_pkg::CFG_IDX_MODE:   mode_r   <= cfg_data[1:0];
        bsad_pkg::CFG_IDX_THRESH: thresh_r <= cfg_data[bsad_pkg::SUM_W-1:0];
        default: ;
      endcase
    end
  end

  // Threshold stop in threshold and half-pel modes; reserved code is plain.
  assign use_thres = (mode_r == bsad_pkg::MODE_THRESH) ||
                     (mode_r == bsad_pkg::MODE_HALFPEL);
  assign halfpel   = (mode_r == bsad_pkg::MODE_HALFPEL);

  bsad_row u_row (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .source_row      (in_ch.source_row),
    .reference_row_a (in_ch.reference_row_a),
    .reference_row_b (in_ch.reference_row_b),
    .halfpel         (halfpel),
    .row_res         (row_res),
    .row_ready       (row_ready)
  );

  bsad_acc u_acc (
    .clk           (clk),
    .rst_n         (rst_n),
    .row_res       (row_res),
    .row_ready     (row_ready),
    .use_thres     (use_thres),
    .threshold     (thresh_r),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .block_sad     (out_ch.block_sad),
    .rows_used     (out_ch.rows_used),
    .stopped_early (out_ch.stopped_early)
  );

endmodule

`default_nettype wire

@@ tb/bsad_result_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsad_result_check: block SAD prediction and result compare
// Watches the row, result and register ports. Keeps its own copy of the
// registers and the block accumulator. Compares every result transaction with
// the oldest predicted block result.
// ----------------------------------------------------------------------------

module bsad_result_check (
  input  logic                            clk,
  input  logic                            rst_n,
  bsad_in_if                              in_ch,
  bsad_out_if                             out_ch,
  input  logic                            cfg_wr_en,
  input  logic [bsad_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bsad_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              results_due
);
  import bsad_pkg::*;

  typedef struct packed {
    logic [SUM_W-1:0]  sad;
    logic [ROWS_W-1:0] rows;
    logic              early;
  } blk_result_t;

  logic [1:0]           mode_q;
  logic [SUM_W-1:0]     thresh_q;
  logic [SUM_W-1:0]     acc_sum;
  logic [ROW_IDX_W-1:0] row_idx;
  logic                 skip_rest;
  blk_result_t          block_sums_q[$];
  int                   fails;

  // Sum of |src - ref| over the eight pixels; ref is A or floor((A + B) / 2).
  function automatic int unsigned row_abs_diff(input logic [ROW_W-1:0] src,
                                               input logic [ROW_W-1:0] ra,
                                               input logic [ROW_W-1:0] rb,
                                               input logic halfpel);
    int unsigned total;
    int unsigned s;
    int unsigned r;
    total = 0;
    for (int k = 0; k < PIXELS_PER_ROW; k++) begin
      s = src[PIX_W*k +: PIX_W];
      r = halfpel ? (int'(ra[PIX_W*k +: PIX_W]) + int'(rb[PIX_W*k +: PIX_W])) >> 1
                  : ra[PIX_W*k +: PIX_W];
      total += (s > r) ? (s - r) : (r - s);
    end
    return total;
  endfunction

  always @(posedge clk) begin : watch
    blk_result_t     got;
    blk_result_t     want;
    logic [ROWS_W-1:0] row_n;
    logic            use_thr;
    if (!rst_n) begin
      mode_q    = MODE_PLAIN;
      thresh_q  = {SUM_W{1'b1}};
      acc_sum   = '0;
      row_idx   = '0;
      skip_rest = 1'b0;
      block_sums_q.delete();
      fails     = 0;
    end else begin
      // Check the result side first: a row taken this edge cannot be done yet.
      if (out_ch.valid && out_ch.ready) begin
        got = '{sad: out_ch.block_sad, rows: out_ch.rows_used, early: out_ch.stopped_early};
        if (block_sums_q.size() == 0) begin
          $display("%0t: unexpected result sad=%0d rows=%0d early=%0b",
                   $realtime, got.sad, got.rows, got.early);
          fails++;
        end else begin
          want = block_sums_q.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch: expected sad=%0d rows=%0d early=%0b, actual sad=%0d rows=%0d early=%0b",
                     $realtime, want.sad, want.rows, want.early,
                     got.sad, got.rows, got.early);
            fails++;
          end
        end
      end

      if (in_ch.valid && in_ch.ready) begin
        row_n = ROWS_W'(row_idx) + 1'b1;
        if (skip_rest) begin
          // Drop the rest of a stopped block, just advance the row count.
          if (row_n >= BLOCK_ROWS) begin
            acc_sum   = '0;
            row_idx   = '0;
            skip_rest = 1'b0;
          end else begin
            row_idx = row_n[ROW_IDX_W-1:0];
          end
        end else begin
          use_thr = (mode_q == MODE_THRESH) || (mode_q == MODE_HALFPEL);
          acc_sum = SUM_W'(acc_sum + row_abs_diff(in_ch.source_row, in_ch.reference_row_a,
                                                  in_ch.reference_row_b,
                                                  mode_q == MODE_HALFPEL));
          if ((use_thr && acc_sum > thresh_q) || row_n >= BLOCK_ROWS) begin
            block_sums_q.push_back('{sad: acc_sum, rows: row_n,
                                     early: use_thr && acc_sum > thresh_q &&
                                            row_n < BLOCK_ROWS});
            if (row_n >= BLOCK_ROWS) begin
              acc_sum   = '0;
              row_idx   = '0;
              skip_rest = 1'b0;
            end else begin
              skip_rest = 1'b1;
              row_idx   = row_n[ROW_IDX_W-1:0];
            end
          end else begin
            row_idx = row_n[ROW_IDX_W-1:0];
          end
        end
      end

      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_IDX_MODE:   mode_q   = cfg_data[1:0];
          CFG_IDX_THRESH: thresh_q = cfg_data[SUM_W-1:0];
          default: ;
        endcase
      end
    end
    results_due <= block_sums_q.size();
    fail_count  <= fails;
  end

endmodule

@@ tb/tb_block_sad_with_early_exit_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_block_sad_with_early_exit_top: block SAD engine testbench
// Drives rows of pixels and register writes into the SAD engine and gives
// the verdict; a side-by-side checker predicts each block result. Directed
// blocks hit the largest sum, the stop on the last row and the half-pel
// floor, then random phases sweep modes, thresholds and row content under
// random idling, a long result stall and a full sender pause.
// ----------------------------------------------------------------------------

module tb_block_sad_with_early_exit_top;
  import bsad_pkg::*;

  localparam int         CYCLE_LIMIT  = 200000;
  localparam int         RANDOM_ROWS  = 750;
  localparam int         DRAIN_CYCLES = 8;
  localparam int         HOLD_CYCLES  = 300;
  // Mode code with no defined meaning; the block treats it as plain mode.
  localparam logic [1:0] MODE_UNDEF   = 2'd3;
  localparam logic [ROW_W-1:0] ROW_ONES = {ROW_W{1'b1}};
  localparam logic [ROW_W-1:0] ROW_ZERO = '0;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    results_due;
  int                    cycle_cnt;
  int                    hold_reqs;
  bit                    no_idle;

  bsad_in_if  in_ch();
  bsad_out_if out_ch();

  block_sad_with_early_exit_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bsad_result_check u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  // 4 ns clock, first rising edge at 2 ns.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Watchdog: count cycles and give up on a hang.
  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("[block_sad_with_early_exit_top] ERROR");
    $finish;
  end

  // Result side: random back-pressure, plus a long hold-off whenever the
  // stimulus asks for one. The hold is counted here, not in the sender.
  initial begin : result_sink
    int hold_done;
    hold_done    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs > hold_done) begin
        hold_done++;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ch.ready <= no_idle || ($urandom_range(99) >= 15);
    end
  end

  // Offer one row; idle first at random, then hold until the handshake.
  // Called and returns on a falling edge.
  task automatic send_row(input logic [ROW_W-1:0] src, input logic [ROW_W-1:0] ra,
                          input logic [ROW_W-1:0] rb);
    while (!no_idle && $urandom_range(99) < 15) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.source_row      <= src;
    in_ch.reference_row_a <= ra;
    in_ch.reference_row_b <= rb;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid and wait for every predicted result, then let the pipeline
  // flush rows that produce no result (dropped rows, partial blocks).
  task automatic drain_block_results();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (results_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write both registers on back-to-back edges; only while idle.
  task automatic set_config(input logic [CFG_DATA_W-1:0] mode_word,
                            input logic [CFG_DATA_W-1:0] thresh);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_IDX_MODE;
    cfg_data  <= mode_word;
    @(negedge clk);
    cfg_index <= CFG_IDX_THRESH;
    cfg_data  <= thresh;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Random row content: mostly noise, some close matches (small sums, late
  // or no stops), saturated pixels and exact matches.
  task automatic make_rows(output logic [ROW_W-1:0] src, output logic [ROW_W-1:0] ra,
                           output logic [ROW_W-1:0] rb);
    int kind;
    kind = $urandom_range(9);
    src  = {$urandom, $urandom};
    ra   = {$urandom, $urandom};
    rb   = {$urandom, $urandom};
    case (kind)
      5, 6: begin
        for (int k = 0; k < PIXELS_PER_ROW; k++) begin
          ra[PIX_W*k +: PIX_W] = src[PIX_W*k +: PIX_W] + PIX_W'($urandom_range(6)) - 8'd3;
          rb[PIX_W*k +: PIX_W] = src[PIX_W*k +: PIX_W] + PIX_W'($urandom_range(6)) - 8'd3;
        end
      end
      7: begin
        for (int k = 0; k < PIXELS_PER_ROW; k++) begin
          src[PIX_W*k +: PIX_W] = $urandom_range(1) ? 8'hFF : 8'h00;
          ra[PIX_W*k +: PIX_W]  = $urandom_range(1) ? 8'hFF : 8'h00;
          rb[PIX_W*k +: PIX_W]  = $urandom_range(1) ? 8'hFF : 8'h00;
        end
      end
      8: ra = src;
      default: ;
    endcase
  endtask

  initial begin : stimulus
    logic [ROW_W-1:0]      src;
    logic [ROW_W-1:0]      ra;
    logic [ROW_W-1:0]      rb;
    logic [CFG_DATA_W-1:0] mode_word;
    logic [CFG_DATA_W-1:0] thresh;
    int                    rand_rows;
    int                    phase_no;
    int                    phase_len;

    rst_n                 = 1'b0;
    cfg_wr_en             = 1'b0;
    cfg_index             = CFG_IDX_MODE;
    cfg_data              = '0;
    in_ch.valid           = 1'b0;
    in_ch.source_row      = '0;
    in_ch.reference_row_a = '0;
    in_ch.reference_row_b = '0;
    hold_reqs             = 0;
    no_idle               = 1'b0;
    rand_rows             = 0;
    phase_no              = 0;

    // Hold reset low from the start, then release it on a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset registers (plain mode): a full block of maximal differences
    // gives the largest possible sum.
    repeat (BLOCK_ROWS) send_row(ROW_ONES, ROW_ZERO, {$urandom, $urandom});
    drain_block_results();

    // Threshold one below the maximum: the stop lands on the last row, so
    // the block is not flagged as stopped early.
    set_config(CFG_DATA_W'(MODE_THRESH), CFG_DATA_W'(16319));
    repeat (BLOCK_ROWS) send_row(ROW_ZERO, ROW_ONES, {$urandom, $urandom});
    drain_block_results();

    // Half-pel with zero threshold: the average floors (1+0 -> 0, 255+0 ->
    // 127), the third row passes the threshold and the rest are dropped.
    set_config(CFG_DATA_W'(MODE_HALFPEL), '0);
    send_row(ROW_ZERO, {PIXELS_PER_ROW{8'h01}}, ROW_ZERO);
    send_row({PIXELS_PER_ROW{8'h7F}}, ROW_ONES, ROW_ZERO);
    send_row(ROW_ONES, ROW_ONES, ROW_ZERO);
    repeat (BLOCK_ROWS - 3) begin
      make_rows(src, ra, rb);
      send_row(src, ra, rb);
    end
    drain_block_results();

    // Random phases: new registers each phase, lengths not tied to block
    // boundaries so that some writes land between rows of a block.
    while (rand_rows < RANDOM_ROWS) begin
      phase_no++;
      mode_word = $urandom_range(1) ? CFG_DATA_W'($urandom) : '0;
      case ($urandom_range(3))
        0: mode_word[1:0] = MODE_PLAIN;
        1: mode_word[1:0] = MODE_THRESH;
        2: mode_word[1:0] = MODE_HALFPEL;
        default: mode_word[1:0] = MODE_UNDEF;
      endcase
      case ($urandom_range(7))
        0: thresh = '0;
        1: thresh = {CFG_DATA_W{1'b1}};
        2, 3: thresh = CFG_DATA_W'($urandom_range(16383));
        default: thresh = CFG_DATA_W'($urandom_range(4000));
      endcase
      // The stall phase needs frequent results so the block backs up.
      if (phase_no == 4) begin
        mode_word = CFG_DATA_W'(MODE_THRESH);
        thresh    = CFG_DATA_W'($urandom_range(1500));
      end
      set_config(mode_word, thresh);

      phase_len = (phase_no inside {2, 4, 6}) ? 64 : $urandom_range(8, 64);
      no_idle   = (phase_no == 2);
      for (int i = 0; i < phase_len; i++) begin
        // Hold the result side off while rows keep coming.
        if (phase_no == 4 && i == 4) hold_reqs++;
        // Pause the sender until every result is out.
        if (phase_no == 6 && i == phase_len / 2) begin
          in_ch.valid <= 1'b0;
          @(negedge clk);
          while (results_due != 0) @(negedge clk);
        end
        make_rows(src, ra, rb);
        send_row(src, ra, rb);
        rand_rows++;
      end
      no_idle = 1'b0;
      drain_block_results();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("[block_sad_with_early_exit_top] OK");
    end else begin
      $display("[block_sad_with_early_exit_top] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/bsad_pkg.sv
rtl/bsad_if.sv
rtl/bsad_row.sv
rtl/bsad_acc.sv
rtl/block_sad_with_early_exit_top.sv
tb/bsad_result_check.sv
tb/tb_block_sad_with_early_exit_top.sv
